// File: rtl/core/pdr_pkg.sv
// Shared constants, types and helpers of the Pareto domination ranking block.
`default_nettype none

package pdr_pkg;

    localparam int MAX_MEMBERS    = 64;
    localparam int MAX_OBJECTIVES = 4;
    localparam int VALUE_WIDTH    = 32;

    localparam int IN_W    = 32;
    localparam int CFG_W   = 3;
    localparam int FIELD_W = 6;

    localparam int IDX_W       = $clog2(MAX_MEMBERS);
    localparam int M_W         = $clog2(MAX_MEMBERS + 1);
    localparam int SLOT_W      = (MAX_OBJECTIVES > 1) ? $clog2(MAX_OBJECTIVES) : 1;
    localparam int OC_W        = $clog2(MAX_OBJECTIVES + 1);
    localparam int STORE_DEPTH = MAX_MEMBERS * MAX_OBJECTIVES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(STORE_DEPTH + 1);

    typedef logic [VALUE_WIDTH-1:0] value_t;

    typedef struct packed {
        logic                               valid;
        logic [MAX_OBJECTIVES-1:0][VALUE_WIDTH-1:0] v;
    } travel_t;

    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_member;
        logic [SLOT_W-1:0] wr_slot;
        value_t            wr_data;
        logic              load_travel;
        logic              shift;
        logic [M_W-1:0]    members;
        logic [OC_W-1:0]   obj_count;
    } cell_ctrl_t;

    // Brings a 32-bit input value to the internal width, wrapping or sign-extending.
    function automatic value_t to_value(input logic signed [IN_W-1:0] x);
        return value_t'(x);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/pdr_cell.sv
// One cell of the ranking ring: holds one member's vector and its domination count.
`default_nettype none

module pdr_cell (
    input  wire logic                     aclk,
    input  wire logic [pdr_pkg::IDX_W-1:0] cell_index,
    input  wire pdr_pkg::cell_ctrl_t      ctrl,
    input  wire pdr_pkg::travel_t         travel_in,
    output pdr_pkg::travel_t              travel_out,
    output logic [pdr_pkg::IDX_W-1:0]     rank
);
    import pdr_pkg::*;

    logic [MAX_OBJECTIVES-1:0][VALUE_WIDTH-1:0] own_reg;
    travel_t                                    travel_reg;
    logic [IDX_W-1:0]                           rank_reg;
    logic                                       own_valid;
    logic                                       beats;

    always_comb begin
        own_valid = int'(cell_index) < int'(ctrl.members);
        beats = 1'b0;
        for (int k = 0; k < MAX_OBJECTIVES; k++) begin
            if (k < int'(ctrl.obj_count) &&
                $signed(own_reg[k]) > $signed(travel_in.v[k])) begin
                beats = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en && ctrl.wr_member == cell_index) begin
            own_reg[ctrl.wr_slot] <= ctrl.wr_data;
        end
        if (ctrl.load_travel) begin
            travel_reg.v     <= own_reg;
            travel_reg.valid <= own_valid;
            rank_reg         <= '0;
        end else if (ctrl.shift) begin
            travel_reg <= travel_in;
            // Count the other member only when this one is larger in no objective.
            if (own_valid && travel_in.valid && !beats) begin
                rank_reg <= rank_reg + IDX_W'(1);
            end
        end
    end

    assign travel_out = travel_reg;
    assign rank       = rank_reg;

endmodule

`default_nettype wire

// File: rtl/core/pareto_domination_rank.sv
// Top level of the Pareto domination ranking block: load store, sequencer and cell ring.
//
// The input channel takes one objective value per transaction, member after member,
// objective_count values to a member; s_last_item on the final value starts ranking.
// Values beyond the store capacity are dropped, and an incomplete last member is ignored.
// While loading, one value is accepted in every cycle and s_ready stays high.
// After the last value, s_ready drops and the block works through these steps:
//   copy every held value from the store into its cell of the ring, start the ring,
//   rotate the ring (every cell compares its own vector with the one passing by),
//   and scan the members to find the minimum rank.
// Then one result per member is offered on the result channel in index order; each
// waits in the output register for as long as m_ready is low, and nothing is lost.
// When the result marked m_last_result has been taken, loading starts again. An
// empty population gives no results and goes straight back to loading.
// The ring rotation and the single read port of the value store set how long these steps last.
// cfg_wr_en writes cfg_wr_data to the configuration register; the user must do so
// between populations, as the block does not enforce it. Reset (aresetn low,
// synchronous) empties the store, returns to loading and sets objective_count to 1.
`default_nettype none

module pareto_domination_rank (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [pdr_pkg::CFG_W-1:0]    cfg_wr_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [pdr_pkg::IN_W-1:0] s_fitness_value,
    input  wire logic                         s_last_item,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [pdr_pkg::FIELD_W-1:0]       m_member_index,
    output logic [pdr_pkg::FIELD_W-1:0]       m_domination_rank,
    output logic                              m_is_best,
    output logic                              m_is_first_best,
    output logic                              m_last_result
);
    import pdr_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DIST,
        ST_PREP,
        ST_CMP,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  objective_count_reg, objective_count_next;
    logic [POS_W-1:0]  load_pos_reg, load_pos_next;
    logic [POS_W-1:0]  p_reg, p_next;
    logic [M_W-1:0]    m_reg, m_next;
    logic [SLOT_W-1:0] k_reg, k_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]  rd_member_reg, rd_member_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [M_W-1:0]    min_reg, min_next;
    logic [IDX_W-1:0]  first_reg, first_next;
    logic              m_valid_reg, m_valid_next;

    value_t            mem [STORE_DEPTH];
    value_t            rd_data_reg;

    logic [OC_W-1:0]   oc_active;
    logic [POS_W-1:0]  capacity;
    logic              in_store;
    logic              s_accept;
    logic              mem_we;
    logic              issue;
    logic [IDX_W-1:0]  rank_sel;

    cell_ctrl_t        cell_ctrl;
    travel_t           travel [MAX_MEMBERS];
    logic [IDX_W-1:0]  cell_rank [MAX_MEMBERS];

    // A count of zero acts as one, and counts above the maximum act as the maximum.
    always_comb begin
        if (objective_count_reg == '0) begin
            oc_active = OC_W'(1);
        end else if (int'(objective_count_reg) > MAX_OBJECTIVES) begin
            oc_active = OC_W'(MAX_OBJECTIVES);
        end else begin
            oc_active = OC_W'(objective_count_reg);
        end
    end

    assign capacity = POS_W'(int'(oc_active) * MAX_MEMBERS);
    assign in_store = load_pos_reg < capacity;
    assign s_ready  = state_reg == ST_LOAD;
    assign s_accept = s_valid && s_ready;
    assign mem_we   = s_accept && in_store;
    assign issue    = (p_reg < load_pos_reg) && (int'(m_reg) < MAX_MEMBERS);
    assign rank_sel = cell_rank[idx_reg];

    always_comb begin
        state_next           = state_reg;
        objective_count_next = objective_count_reg;
        load_pos_next        = load_pos_reg;
        p_next               = p_reg;
        m_next               = m_reg;
        k_next               = k_reg;
        rd_valid_next        = 1'b0;
        rd_member_next       = rd_member_reg;
        rd_slot_next         = rd_slot_reg;
        cnt_next             = cnt_reg;
        idx_next             = idx_reg;
        min_next             = min_reg;
        first_next           = first_reg;
        m_valid_next         = m_valid_reg;

        if (cfg_wr_en) begin
            objective_count_next = cfg_wr_data;
        end

        case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    if (in_store) begin
                        load_pos_next = load_pos_reg + POS_W'(1);
                    end
                    if (s_last_item) begin
                        p_next     = '0;
                        m_next     = '0;
                        k_next     = '0;
                        state_next = ST_DIST;
                    end
                end
            end
            ST_DIST: begin
                if (issue) begin
                    p_next         = p_reg + POS_W'(1);
                    rd_valid_next  = 1'b1;
                    rd_member_next = IDX_W'(m_reg);
                    rd_slot_next   = k_reg;
                    if (int'(k_reg) == int'(oc_active) - 1) begin
                        k_next = '0;
                        m_next = m_reg + M_W'(1);
                    end else begin
                        k_next = k_reg + SLOT_W'(1);
                    end
                end else if (!rd_valid_reg) begin
                    // The last copied value has reached its cell.
                    load_pos_next = '0;
                    if (m_reg == '0) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                cnt_next   = '0;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (int'(cnt_reg) == MAX_MEMBERS - 2) begin
                    idx_next   = '0;
                    min_next   = M_W'(MAX_MEMBERS);
                    first_next = '0;
                    state_next = ST_SCAN;
                end else begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_SCAN: begin
                if (int'(rank_sel) < int'(min_reg)) begin
                    min_next   = M_W'(rank_sel);
                    first_next = idx_reg;
                end
                if (int'(idx_reg) + 1 == int'(m_reg)) begin
                    idx_next     = '0;
                    m_valid_next = 1'b1;
                    state_next   = ST_EMIT;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_EMIT: begin
                if (m_ready) begin
                    if (int'(idx_reg) + 1 == int'(m_reg)) begin
                        m_valid_next = 1'b0;
                        state_next   = ST_LOAD;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_LOAD;
            objective_count_reg <= CFG_W'(1);
            load_pos_reg        <= '0;
            p_reg               <= '0;
            m_reg               <= '0;
            k_reg               <= '0;
            rd_valid_reg        <= 1'b0;
            rd_member_reg       <= '0;
            rd_slot_reg         <= '0;
            cnt_reg             <= '0;
            idx_reg             <= '0;
            min_reg             <= '0;
            first_reg           <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg           <= state_next;
            objective_count_reg <= objective_count_next;
            load_pos_reg        <= load_pos_next;
            p_reg               <= p_next;
            m_reg               <= m_next;
            k_reg               <= k_next;
            rd_valid_reg        <= rd_valid_next;
            rd_member_reg       <= rd_member_next;
            rd_slot_reg         <= rd_slot_next;
            cnt_reg             <= cnt_next;
            idx_reg             <= idx_next;
            min_reg             <= min_next;
            first_reg           <= first_next;
            m_valid_reg         <= m_valid_next;
        end
    end

    // Flat value store: written while loading, read once per value while copying.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[load_pos_reg[ADDR_W-1:0]] <= to_value(s_fitness_value);
        end
        rd_data_reg <= mem[p_reg[ADDR_W-1:0]];
    end

    always_comb begin
        cell_ctrl.wr_en       = rd_valid_reg;
        cell_ctrl.wr_member   = rd_member_reg;
        cell_ctrl.wr_slot     = rd_slot_reg;
        cell_ctrl.wr_data     = rd_data_reg;
        cell_ctrl.load_travel = state_reg == ST_PREP;
        cell_ctrl.shift       = state_reg == ST_CMP;
        cell_ctrl.members     = m_reg;
        cell_ctrl.obj_count   = oc_active;
    end

    // The cells form a ring, so every vector passes every other cell once.
    for (genvar g = 0; g < MAX_MEMBERS; g++) begin : g_cell
        pdr_cell u_cell (
            .aclk       (aclk),
            .cell_index (IDX_W'(g)),
            .ctrl       (cell_ctrl),
            .travel_in  (travel[(g + MAX_MEMBERS - 1) % MAX_MEMBERS]),
            .travel_out (travel[g]),
            .rank       (cell_rank[g])
        );
    end

    assign m_valid           = m_valid_reg;
    assign m_member_index    = FIELD_W'(idx_reg);
    assign m_domination_rank = FIELD_W'(rank_sel);
    assign m_is_best         = int'(rank_sel) == int'(min_reg);
    assign m_is_first_best   = idx_reg == first_reg;
    assign m_last_result     = int'(idx_reg) + 1 == int'(m_reg);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input accepted while a result is pending");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> int'(idx_reg) < int'(m_reg))
        else $error("result index beyond population");

    a_first_is_best: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_first_best |-> m_is_best)
        else $error("first best member does not hold the minimum rank");

    a_reload_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_result |=> s_ready && !m_valid)
        else $error("loading did not resume after the final result");

    a_copy_only_in_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> state_reg == ST_DIST)
        else $error("cell write outside the copy phase");

endmodule

`default_nettype wire
